/* hdl/hlmd_pkg.sv */
package hlmd_pkg;

   typedef enum logic {
      ACT_MUL = 1'b0,
      ACT_DIV = 1'b1
   } action_type;

endpackage

/* hdl/hi_lo_multiply_divide_unit.sv */
// Pipelined HI/LO multiply/divide unit. A request enters every cycle unless
// a stalled response holds the pipeline. One stage takes operand magnitudes,
// WORD_WIDTH stages each retire one restoring-divide quotient bit, and the
// output register fixes signs and holds the response. The signed multiply runs
// beside the divide chain as a registered multiply followed by a delay line of
// the same length. One global enable stalls every stage when the response is
// not taken, so nothing is lost.
module hi_lo_multiply_divide_unit #(
   parameter int WORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // action, operand_a, operand_b, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // hi_value, lo_value, divide_by_zero, zero fill
);
   import hlmd_pkg::*;

   localparam int W      = WORD_WIDTH;
   localparam int STAGES = W + 1;

   typedef struct packed {
      logic   is_div;
      logic   dz;
      logic   neg_q;
      logic   neg_r;
      logic [W-1:0] dividend;
   } ctl_type;

   logic advance;
   logic [STAGES-1:0] valid_ff;
   logic out_valid_ff;
   logic [31:0] out_hi_ff, out_lo_ff;
   logic out_dz_ff;

   logic [W-1:0] a_w, b_w;
   assign a_w = req_tdata[1 +: W];
   assign b_w = req_tdata[33 +: W];

   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = advance;

   ctl_type ctl_ff [STAGES];
   logic [2*W-1:0] prod_ff [STAGES];
   logic [W-1:0] rem_s [W+1];
   logic [W-1:0] quo_s [W+1];
   logic [W-1:0] divisor_ff [W];
   logic [W-1:0] ma_ff;

   ctl_type ctl_in;
   logic [W-1:0] ma_in, mb_in;
   logic signed [2*W-1:0] prod_in;
   always_comb begin
      ctl_in.is_div   = req_tdata[0] == ACT_DIV;
      ctl_in.dz       = b_w == '0;
      ctl_in.neg_q    = a_w[W-1] ^ b_w[W-1];
      ctl_in.neg_r    = a_w[W-1];
      ctl_in.dividend = a_w;
      ma_in = a_w[W-1] ? W'(-a_w) : a_w;
      mb_in = b_w[W-1] ? W'(-b_w) : b_w;
      prod_in = $signed(a_w) * $signed(b_w);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0]     <= ctl_in;
         prod_ff[0]    <= prod_in;
         ma_ff         <= ma_in;
         divisor_ff[0] <= mb_in;
         for (int i = 1; i < STAGES; i++) begin
            ctl_ff[i]  <= ctl_ff[i-1];
            prod_ff[i] <= prod_ff[i-1];
         end
         for (int i = 1; i < W; i++) begin
            divisor_ff[i] <= divisor_ff[i-1];
         end
      end
   end

   assign rem_s[0] = '0;
   assign quo_s[0] = ma_ff;

   for (genvar g = 0; g < W; g++) begin : g_div
      hlmd_div_stage #(.WORD_WIDTH(W)) u_stage (
         .clock   (clock),
         .advance (advance),
         .rem_in  (rem_s[g]),
         .quo_in  (quo_s[g]),
         .div_in  (divisor_ff[g]),
         .rem_out (rem_s[g+1]),
         .quo_out (quo_s[g+1])
      );
   end

   ctl_type ctl_l;
   logic [W-1:0] hi_w, lo_w;
   logic dz_w;
   always_comb begin
      ctl_l = ctl_ff[STAGES-1];
      dz_w  = 1'b0;
      if (!ctl_l.is_div) begin
         hi_w = prod_ff[STAGES-1][2*W-1:W];
         lo_w = prod_ff[STAGES-1][W-1:0];
      end else if (ctl_l.dz) begin
         hi_w = ctl_l.dividend;
         lo_w = '1;
         dz_w = 1'b1;
      end else begin
         hi_w = ctl_l.neg_r ? W'(-rem_s[W]) : rem_s[W];
         lo_w = ctl_l.neg_q ? W'(-quo_s[W]) : quo_s[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[STAGES-2:0], req_tvalid};
         out_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hi_ff <= 32'(hi_w);
         out_lo_ff <= 32'(lo_w);
         out_dz_ff <= dz_w;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_dz_ff, out_lo_ff, out_hi_ff};

   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("ready while response stalled");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[63:32] == 32'(W'('1)))
      else $error("divide by zero quotient not all ones");

endmodule

/* hdl/hlmd_div_stage.sv */
module hlmd_div_stage #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [WORD_WIDTH-1:0] rem_in,
   input  logic [WORD_WIDTH-1:0] quo_in,
   input  logic [WORD_WIDTH-1:0] div_in,
   output logic [WORD_WIDTH-1:0] rem_out,
   output logic [WORD_WIDTH-1:0] quo_out
);

   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH-1:0] rem_ff;
   logic [WORD_WIDTH-1:0] quo_ff;
   logic [WORD_WIDTH-1:0] rem_in_w;
   logic [WORD_WIDTH-1:0] quo_in_w;

   always_comb begin
      trial    = {rem_in, quo_in[WORD_WIDTH-1]};
      diff     = trial - {1'b0, div_in};
      quo_in_w = {quo_in[WORD_WIDTH-2:0], ~diff[WORD_WIDTH]};
      rem_in_w = diff[WORD_WIDTH] ? trial[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_w;
         quo_ff <= quo_in_w;
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

/* dv/hlmd_checker.sv */
`timescale 1ns / 1ps

module hlmd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   import hlmd_pkg::*;

   typedef struct packed {
      logic [31:0] hi_value;
      logic [31:0] lo_value;
      logic        divide_by_zero;
   } hilo_result_type;

   hilo_result_type expected_results[$];

   function automatic hilo_result_type compute_hilo(action_type act, logic [31:0] a,
                                                    logic [31:0] b);
      hilo_result_type    r;
      logic signed [63:0] sa, sb, prod;
      logic [31:0]        ma, mb, q, rem;
      sa = {{32{a[31]}}, a};
      sb = {{32{b[31]}}, b};
      r.divide_by_zero = 1'b0;
      if (act == ACT_MUL) begin
         prod = sa * sb;
         r.hi_value = prod[63:32];
         r.lo_value = prod[31:0];
      end else if (b == 32'd0) begin
         r.hi_value = a;
         r.lo_value = 32'hffffffff;
         r.divide_by_zero = 1'b1;
      end else begin
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q = ma / mb;
         rem = ma % mb;
         if (a[31] != b[31]) q = -q;
         if (a[31]) rem = -rem;
         r.hi_value = rem;
         r.lo_value = q;
      end
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      hilo_result_type exp_r, got_r;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            exp_r = compute_hilo(action_type'(req_tdata[0]), req_tdata[32:1],
                                 req_tdata[64:33]);
            expected_results.push_back(exp_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_r = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[64]};
            if (expected_results.size() == 0) begin
               $display("%0t: response with none expected: %h", $time, got_r);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (got_r !== exp_r || rsp_tdata[71:65] !== 7'd0) begin
                  $display("%0t: mismatch expected hi %h lo %h dz %b, actual %h",
                           $time, exp_r.hi_value, exp_r.lo_value,
                           exp_r.divide_by_zero, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* dv/tb_hi_lo_multiply_divide_unit.sv */
`timescale 1ns / 1ps

module tb_hi_lo_multiply_divide_unit;
   import hlmd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   bit          stimulus_done;

   hi_lo_multiply_divide_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hlmd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'hffffffff;
         2: return 32'd0;
         3: return $urandom_range(0, 15);
         4: return -$urandom_range(1, 15);
         5: return 32'h7fffffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(action_type act, logic [31:0] a, logic [31:0] b);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, b, a, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [31:0] corners[6];
      corners = '{32'd0, 32'd1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'd7};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      stimulus_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (corners[i]) begin
         send_request(ACT_MUL, corners[i], corners[(i + 3) % 6]);
         send_request(ACT_DIV, corners[i], corners[(i + 2) % 6]);
      end
      send_request(ACT_DIV, 32'h80000000, 32'hffffffff);
      send_request(ACT_DIV, 32'hfffffff9, 32'hfffffffe);
      send_request(ACT_DIV, 32'hfffffff9, 32'd2);
      send_request(ACT_DIV, 32'd7, 32'hfffffffe);
      send_request(ACT_MUL, 32'h80000000, 32'h80000000);
      repeat (1350)
         send_request(action_type'($urandom_range(0, 1)), pick_operand(),
                      pick_operand());
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      wait (stimulus_done);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #1000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
hdl/hlmd_pkg.sv
hdl/hlmd_div_stage.sv
hdl/hi_lo_multiply_divide_unit.sv
dv/hlmd_checker.sv
dv/tb_hi_lo_multiply_divide_unit.sv
